FILE: hdl/mmr_pkg.sv
`timescale 1ns / 1ps

package mmr_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned NB_W    = 4;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned WORD_BY = 8;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DROP = 2'd1,
    ST_FULL = 2'd2,
    ST_LONG = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_META,
    S_RD,
    S_OUT,
    S_STAT
  } state_e;

  // per-slot bookkeeping held in the slot memory
  typedef struct packed {
    logic [7:0]       last_pkt;
    logic [6:0]       word_cnt;
    logic [LEN_W-1:0] byte_tot;
  } meta_t;

endpackage

FILE: hdl/multipacket_message_reassembly.sv
`timescale 1ns / 1ps

// Message reassembly. Payload beats tagged with source/message ids are
// collected per message in a table of SLOTS entries, each holding up to
// MESSAGE_WORDS words in one payload RAM; per-slot counters sit in a small
// slot RAM with registered read. The block works on one beat at a time: a
// continuation beat is accepted, then the slot RAM read-modify-write and
// payload write follow; a beat with packet_start first passes S_LOOK
// for the key match and free-slot pick. A status result (drop, table full,
// too long) holds the block until it is taken. When the final packet ends,
// the stored words stream out in order, each word read from the payload RAM
// and then presented at the output; no input beat is taken while a message
// streams. No clearing pass after reset: slot valid bits sit in flops.
module multipacket_message_reassembly #(
  parameter int unsigned SLOTS         = 8,
  parameter int unsigned MESSAGE_WORDS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [15:0]                 source_ident_i,
  input  logic [15:0]                 message_ident_i,
  input  logic [7:0]                  packet_number_i,
  input  logic [7:0]                  packet_total_i,
  input  logic [63:0]                 payload_word_i,
  input  logic [3:0]                  word_bytes_i,
  input  logic                        packet_start_i,
  input  logic                        packet_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_code_o,
  output logic [15:0]                 out_source_o,
  output logic [15:0]                 out_message_o,
  output logic [7:0]                  out_packet_total_o,
  output logic [63:0]                 out_word_o,
  output logic [3:0]                  out_bytes_o,
  output logic [9:0]                  total_length_o,
  output logic                        last_word_o
);
  import mmr_pkg::*;

  localparam int unsigned DEPTH = SLOTS * MESSAGE_WORDS;
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(MESSAGE_WORDS + 1);

  state_e state_q, state_d;

  // captured input beat
  logic [15:0]       src_q, msg_q;
  logic [7:0]        num_q, tot_q;
  logic [63:0]       word_q;
  logic [NB_W-1:0]   nb_q;
  logic              start_q, end_q;
  logic [63:0]       word_m;
  logic [NB_W-1:0]   nb_c;

  // current packet
  logic              act_q, act_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [15:0]       csrc_q, cmsg_q;
  logic [7:0]        ctot_q;
  logic              hit_q, hit_d;
  logic              fresh_q, fresh_d;

  // slot table
  logic [SLOTS-1:0]  vld_q, vld_d;
  logic [KEY_W-1:0]  key_q [SLOTS];
  logic              key_we;

  // slot RAM
  meta_t             meta_mem [SLOTS];
  meta_t             meta_rd_q;
  meta_t             meta_wd;
  logic              meta_we;
  logic [SW-1:0]     meta_ra;

  // payload RAM: {byte count, data}
  logic [NB_W+WORD_W-1:0] pay_mem [DEPTH];
  logic [NB_W+WORD_W-1:0] pay_rd_q;
  logic              pay_we;
  logic [PAW-1:0]    pay_wa, pay_ra;

  // streaming and status
  logic [CW-1:0]     idx_q, idx_d, n_q, n_d;
  logic [LEN_W-1:0]  len_q, len_d;
  status_e           stat_q, stat_d;

  // lookup
  logic [SLOTS-1:0]  hit_vec;
  logic [SW-1:0]     hit_idx, free_idx;
  logic              any_hit, any_free;

  // slot RAM decision
  meta_t             cur_m;
  logic              drop_seq, too_long, done;
  logic [CW-1:0]     cnt_ext;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // byte count clamp and masking of bytes above it
  always_comb begin
    nb_c = (word_bytes_i > NB_W'(WORD_BY)) ? NB_W'(WORD_BY) : word_bytes_i;
    for (int b = 0; b < WORD_BY; b++) begin
      word_m[b*8 +: 8] = (NB_W'(b) < nb_c) ? payload_word_i[b*8 +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      src_q   <= source_ident_i;
      msg_q   <= message_ident_i;
      num_q   <= packet_number_i;
      tot_q   <= packet_total_i;
      word_q  <= word_m;
      nb_q    <= nb_c;
      start_q <= packet_start_i;
      end_q   <= packet_end_i;
    end
  end

  // key match against every slot, lowest hit and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    any_hit  = 1'b0;
    any_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      hit_vec[i] = vld_q[i] && (key_q[i] == {src_q, msg_q});
      if (hit_vec[i]) begin
        hit_idx = SW'(i);
        any_hit = 1'b1;
      end
      if (!vld_q[i]) begin
        free_idx = SW'(i);
        any_free = 1'b1;
      end
    end
  end

  // slot RAM state after header handling
  always_comb begin
    cur_m    = meta_rd_q;
    drop_seq = 1'b0;
    if (fresh_q) begin
      cur_m = '{last_pkt: 8'd1, word_cnt: '0, byte_tot: '0};
    end else if (start_q && hit_q) begin
      if ({1'b0, num_q} == {1'b0, meta_rd_q.last_pkt} + 9'd1) begin
        cur_m.last_pkt = num_q;
      end else if (num_q == 8'd1) begin
        cur_m = '{last_pkt: 8'd1, word_cnt: '0, byte_tot: '0};
      end else begin
        drop_seq = 1'b1;
      end
    end
    cnt_ext  = CW'(cur_m.word_cnt);
    too_long = (32'(cur_m.word_cnt) >= MESSAGE_WORDS);
    done     = end_q && (cur_m.last_pkt == ctot_q);
    meta_wd  = '{last_pkt: cur_m.last_pkt,
                 word_cnt: cur_m.word_cnt + 7'd1,
                 byte_tot: cur_m.byte_tot + LEN_W'(nb_q)};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (packet_start_i) begin
            state_d = S_LOOK;
          end else if (act_q) begin
            state_d = S_META;
          end
        end
      end
      S_LOOK: begin
        if (!any_hit && (num_q != 8'd1 || !any_free)) begin
          state_d = S_STAT;
        end else begin
          state_d = S_META;
        end
      end
      S_META: begin
        if (drop_seq || too_long) begin
          state_d = S_STAT;
        end else if (done) begin
          state_d = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD:   state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) begin
          state_d = (idx_q + CW'(1) == n_q) ? S_IDLE : S_RD;
        end
      end
      S_STAT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // handshake and result fields
  always_comb begin
    in_ready_o         = (state_q == S_IDLE);
    out_valid_o        = (state_q == S_OUT) || (state_q == S_STAT);
    out_source_o       = csrc_q;
    out_message_o      = cmsg_q;
    out_packet_total_o = ctot_q;
    if (state_q == S_OUT) begin
      status_code_o  = ST_DATA;
      out_word_o     = pay_rd_q[WORD_W-1:0];
      out_bytes_o    = pay_rd_q[NB_W+WORD_W-1:WORD_W];
      total_length_o = len_q;
      last_word_o    = (idx_q + CW'(1) == n_q);
    end else begin
      status_code_o  = stat_q;
      out_word_o     = '0;
      out_bytes_o    = '0;
      total_length_o = '0;
      last_word_o    = 1'b1;
    end
  end

  // datapath and table updates
  always_comb begin
    act_d   = act_q;
    slot_d  = slot_q;
    hit_d   = hit_q;
    fresh_d = fresh_q;
    vld_d   = vld_q;
    key_we  = 1'b0;
    meta_we = 1'b0;
    pay_we  = 1'b0;
    idx_d   = idx_q;
    n_d     = n_q;
    len_d   = len_q;
    stat_d  = stat_q;
    meta_ra = slot_q;
    pay_wa  = PAW'(slot_q) * PAW'(MESSAGE_WORDS) + PAW'(cnt_ext);
    pay_ra  = PAW'(slot_q) * PAW'(MESSAGE_WORDS) + PAW'(idx_q);
    case (state_q)
      S_IDLE: begin
        fresh_d = 1'b0;
        hit_d   = 1'b0;
        if (in_acc && packet_start_i) begin
          act_d = 1'b0;
        end
      end
      S_LOOK: begin
        hit_d   = any_hit;
        fresh_d = !any_hit;
        slot_d  = any_hit ? hit_idx : free_idx;
        meta_ra = any_hit ? hit_idx : free_idx;
        if (!any_hit) begin
          if (num_q != 8'd1) begin
            stat_d = ST_DROP;
          end else if (!any_free) begin
            stat_d = ST_FULL;
          end else begin
            vld_d[free_idx] = 1'b1;
            key_we          = 1'b1;
          end
        end
      end
      S_META: begin
        if (drop_seq) begin
          vld_d[slot_q] = 1'b0;
          stat_d        = ST_DROP;
        end else if (too_long) begin
          vld_d[slot_q] = 1'b0;
          act_d         = 1'b0;
          stat_d        = ST_LONG;
        end else begin
          meta_we = 1'b1;
          pay_we  = 1'b1;
          act_d   = !end_q;
          if (done) begin
            vld_d[slot_q] = 1'b0;
            idx_d         = '0;
            n_d           = cnt_ext + CW'(1);
            len_d         = meta_wd.byte_tot;
          end
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= 1'b0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    hit_q   <= hit_d;
    fresh_q <= fresh_d;
    idx_q   <= idx_d;
    n_q     <= n_d;
    len_q   <= len_d;
    stat_q  <= stat_d;
    if (state_q == S_LOOK) begin
      csrc_q <= src_q;
      cmsg_q <= msg_q;
      ctot_q <= tot_q;
    end
    if (key_we) begin
      key_q[free_idx] <= {src_q, msg_q};
    end
  end

  // slot RAM
  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[slot_q] <= meta_wd;
    end
    meta_rd_q <= meta_mem[meta_ra];
  end

  // payload RAM
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_wa] <= {nb_q, word_q};
    end
    if (state_q == S_RD) begin
      pay_rd_q <= pay_mem[pay_ra];
    end
  end

endmodule

FILE: hdl/mmr_checker.sv
`timescale 1ns / 1ps

module mmr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_code_o,
  input logic [63:0] out_word_o,
  input logic [3:0]  out_bytes_o,
  input logic [9:0]  total_length_o,
  input logic        last_word_o
);
  import mmr_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o)
      && $stable(status_code_o) && $stable(last_word_o))
    else $error("result beat changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_code_o != ST_DATA |->
      last_word_o && out_bytes_o == 4'd0 && out_word_o == 64'd0
      && total_length_o == 10'd0)
    else $error("status beat carries data");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_code_o == ST_DATA |->
      out_bytes_o <= 4'd8 && total_length_o <= 10'd512)
    else $error("data beat count out of range");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

endmodule

bind multipacket_message_reassembly mmr_checker u_mmr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_code_o  (status_code_o),
  .out_word_o     (out_word_o),
  .out_bytes_o    (out_bytes_o),
  .total_length_o (total_length_o),
  .last_word_o    (last_word_o)
);
